// ===== hw/rtl/pdfp_pkg.sv =====
// Shared types and constants for the format directive parser.
package pdfp_pkg;

  // Default parameter values and fixed widths
  localparam int unsigned POSITION_BITS_DEF   = 16;
  localparam int unsigned DIRECTIVE_LIMIT_DEF = 256;
  localparam int unsigned QUEUE_DEPTH         = 4;
  localparam int unsigned CFG_W               = 9;
  localparam int unsigned OUT_DATA_W          = 80;
  localparam logic [8:0]  MAX_DIR_RESET       = 9'd64;

  // Status codes of a status record
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_MANY = 2'd2
  } status_e;

  // Directive kinds
  localparam logic [3:0] KIND_ORD = 4'd0;
  localparam logic [3:0] KIND_D   = 4'd1;
  localparam logic [3:0] KIND_U   = 4'd2;
  localparam logic [3:0] KIND_XL  = 4'd3;
  localparam logic [3:0] KIND_XU  = 4'd4;
  localparam logic [3:0] KIND_S   = 4'd5;
  localparam logic [3:0] KIND_P   = 4'd6;
  localparam logic [3:0] KIND_C   = 4'd7;

  // Character codes
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_H    = 8'h68;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_XU   = 8'h58;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_P    = 8'h70;
  localparam logic [7:0] CH_C    = 8'h63;

  // One result record, fields as they leave the block
  typedef struct packed {
    logic        is_status;
    logic [3:0]  kind;
    logic [15:0] fwidth;
    logic        zpad;
    logic [15:0] rstart;
    logic [15:0] rlen;
    status_e     code;
    logic [15:0] epos;
    logic [8:0]  count;
  } rec_t;

  // Queue entry: split marks a closing run that expands into run record plus
  // success status, the status count traveling in rec.count
  typedef struct packed {
    logic split;
    rec_t rec;
  } entry_t;

endpackage

// ===== hw/rtl/pdfp_front.sv =====
// Front end: accepts characters, runs the parse state machine, queues records.
module pdfp_front #(
  parameter int unsigned POSITION_BITS   = 16,
  parameter int unsigned DIRECTIVE_LIMIT = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [8:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_char_i,
  input  logic                 in_end_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output pdfp_pkg::entry_t     q_entry_o
);
  import pdfp_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIRECTIVE_LIMIT + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [7:0] {
    PH_TEXT = 8'b0000_0001,
    PH_ORD  = 8'b0000_0010,
    PH_NUM  = 8'b0000_0100,
    PH_DIG  = 8'b0000_1000,
    PH_L1   = 8'b0001_0000,
    PH_H1   = 8'b0010_0000,
    PH_CONV = 8'b0100_0000,
    PH_SKIP = 8'b1000_0000
  } phase_e;

  phase_e                   phase_q, phase_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]         records_q, records_d;
  logic [POSITION_BITS-1:0] ord_start_q, ord_start_d;
  logic [15:0]              ord_len_q, ord_len_d;
  logic [15:0]              width_q, width_d;
  logic                     zero_q, zero_d;
  logic [1:0]               long_q, long_d;
  logic [8:0]               max_dir_q;

  logic             accept;
  logic             is_digit;
  logic             finish;
  logic             at_limit;
  logic [CMP_W-1:0] limit;
  logic [19:0]      wide_width;
  logic [3:0]       conv_kind;

  // Map a conversion character and length level to a kind, zero if invalid
  function automatic logic [3:0] classify(logic [7:0] c, logic [1:0] lvl);
    logic [3:0] base;
    logic [3:0] kind;
    base = KIND_ORD;
    kind = KIND_ORD;
    priority if (c == CH_D)  base = KIND_D;
    else if     (c == CH_U)  base = KIND_U;
    else if     (c == CH_X)  base = KIND_XL;
    else if     (c == CH_XU) base = KIND_XU;
    else                     base = KIND_ORD;
    if (base != KIND_ORD) begin
      kind = base + {lvl, 2'b00};
    end else if (lvl == 2'd0) begin
      priority if (c == CH_S) kind = KIND_S;
      else if     (c == CH_P) kind = KIND_P;
      else if     (c == CH_C) kind = KIND_C;
      else                    kind = KIND_ORD;
    end
    return kind;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (in_char_i >= CH_0) && (in_char_i <= CH_9);

  // Effective directive limit and overflow check
  assign limit = (CMP_W'(max_dir_q) < CMP_W'(DIRECTIVE_LIMIT)) ?
                 CMP_W'(max_dir_q) : CMP_W'(DIRECTIVE_LIMIT);
  assign at_limit = CMP_W'(records_q) >= limit;

  // Width accumulate by ten plus the new digit
  assign wide_width = 20'(width_q) * 20'd10 + 20'(in_char_i[3:0]);
  assign conv_kind  = classify(in_char_i, long_q);

  // Parse step
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    records_d   = records_q;
    ord_start_d = ord_start_q;
    ord_len_d   = ord_len_q;
    width_d     = width_q;
    zero_d      = zero_q;
    long_d      = long_q;
    q_push_o    = 1'b0;
    q_entry_o   = '0;
    finish      = 1'b0;

    if (accept && in_end_i) begin
      unique case (phase_q)
        PH_TEXT: begin
          q_push_o                 = 1'b1;
          q_entry_o.rec.is_status  = 1'b1;
          q_entry_o.rec.code       = ST_OK;
          q_entry_o.rec.count      = 9'(records_q);
        end
        PH_ORD: begin
          q_push_o             = 1'b1;
          q_entry_o.split      = 1'b1;
          q_entry_o.rec.kind   = KIND_ORD;
          q_entry_o.rec.rstart = 16'(ord_start_q);
          q_entry_o.rec.rlen   = ord_len_q;
          q_entry_o.rec.count  = 9'(records_q + 1'b1);
        end
        PH_SKIP: begin
          q_push_o = 1'b0;
        end
        default: begin
          q_push_o                 = 1'b1;
          q_entry_o.rec.is_status  = 1'b1;
          q_entry_o.rec.code       = ST_INVALID;
          q_entry_o.rec.epos       = 16'(pos_q);
          q_entry_o.rec.count      = 9'(records_q);
        end
      endcase
      // Rearm for the next string
      phase_d     = PH_TEXT;
      pos_d       = '0;
      records_d   = '0;
      ord_start_d = '0;
      ord_len_d   = '0;
      width_d     = '0;
      zero_d      = 1'b0;
      long_d      = 2'd0;
    end else if (accept) begin
      if (pos_q != '1) begin
        pos_d = pos_q + 1'b1;
      end
      unique case (phase_q)
        PH_TEXT: begin
          if (in_char_i == CH_PCT) begin
            width_d = '0;
            zero_d  = 1'b0;
            long_d  = 2'd0;
            phase_d = PH_NUM;
          end else if (at_limit) begin
            q_push_o                = 1'b1;
            q_entry_o.rec.is_status = 1'b1;
            q_entry_o.rec.code      = ST_TOO_MANY;
            q_entry_o.rec.epos      = 16'(pos_q);
            q_entry_o.rec.count     = 9'(records_q);
            phase_d                 = PH_SKIP;
          end else begin
            ord_start_d = pos_q;
            ord_len_d   = 16'd1;
            phase_d     = PH_ORD;
          end
        end
        PH_ORD: begin
          if (in_char_i == CH_PCT) begin
            q_push_o             = 1'b1;
            q_entry_o.rec.kind   = KIND_ORD;
            q_entry_o.rec.rstart = 16'(ord_start_q);
            q_entry_o.rec.rlen   = ord_len_q;
            records_d            = records_q + 1'b1;
            width_d              = '0;
            zero_d               = 1'b0;
            long_d               = 2'd0;
            phase_d              = PH_NUM;
          end else if (ord_len_q != 16'hFFFF) begin
            ord_len_d = ord_len_q + 16'd1;
          end
        end
        PH_NUM, PH_DIG: begin
          if (phase_q == PH_NUM && in_char_i == CH_0) begin
            zero_d  = 1'b1;
            phase_d = PH_DIG;
          end else if (is_digit) begin
            width_d = (wide_width > 20'hFFFF) ? 16'hFFFF : wide_width[15:0];
            phase_d = PH_DIG;
          end else if (in_char_i == CH_DOT || in_char_i == CH_DASH) begin
            width_d = '0;
            zero_d  = 1'b0;
            long_d  = 2'd0;
            phase_d = PH_NUM;
          end else if (in_char_i == CH_L) begin
            long_d  = 2'd1;
            phase_d = PH_L1;
          end else if (in_char_i == CH_H) begin
            phase_d = PH_H1;
          end else begin
            finish = 1'b1;
          end
        end
        PH_L1: begin
          if (in_char_i == CH_L) begin
            long_d  = 2'd2;
            phase_d = PH_CONV;
          end else if (in_char_i == CH_H) begin
            phase_d = PH_H1;
          end else begin
            finish = 1'b1;
          end
        end
        PH_H1: begin
          if (in_char_i == CH_H) begin
            phase_d = PH_CONV;
          end else begin
            finish = 1'b1;
          end
        end
        PH_CONV: begin
          finish = 1'b1;
        end
        default: begin
          phase_d = PH_SKIP;
        end
      endcase

      // Close a conversion: overflow first, then validity
      if (finish) begin
        q_push_o = 1'b1;
        if (at_limit) begin
          q_entry_o.rec.is_status = 1'b1;
          q_entry_o.rec.code      = ST_TOO_MANY;
          q_entry_o.rec.epos      = 16'(pos_q);
          q_entry_o.rec.count     = 9'(records_q);
          phase_d                 = PH_SKIP;
        end else if (conv_kind == KIND_ORD) begin
          q_entry_o.rec.is_status = 1'b1;
          q_entry_o.rec.code      = ST_INVALID;
          q_entry_o.rec.epos      = 16'(pos_q);
          q_entry_o.rec.count     = 9'(records_q);
          phase_d                 = PH_SKIP;
        end else begin
          q_entry_o.rec.kind   = conv_kind;
          q_entry_o.rec.fwidth = width_q;
          q_entry_o.rec.zpad   = zero_q;
          records_d            = records_q + 1'b1;
          phase_d              = PH_TEXT;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TEXT;
      pos_q       <= '0;
      records_q   <= '0;
      ord_start_q <= '0;
      ord_len_q   <= '0;
      width_q     <= '0;
      zero_q      <= 1'b0;
      long_q      <= 2'd0;
      max_dir_q   <= MAX_DIR_RESET;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      records_q   <= records_d;
      ord_start_q <= ord_start_d;
      ord_len_q   <= ord_len_d;
      width_q     <= width_d;
      zero_q      <= zero_d;
      long_q      <= long_d;
      if (cfg_we_i) begin
        max_dir_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== hw/rtl/pdfp_fifo.sv =====
// Small register queue of record entries between front and back end.
module pdfp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pdfp_pkg::entry_t entry_i,
  input  logic             pop_i,
  output pdfp_pkg::entry_t head_o,
  output logic             full_o,
  output logic             empty_o
);
  import pdfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/pdfp_back.sv =====
// Back end: expands queued entries into result records in an output register.
module pdfp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  pdfp_pkg::entry_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pdfp_pkg::rec_t   out_rec_o,
  output logic             out_last_o
);
  import pdfp_pkg::*;

  logic valid_q, valid_d;
  logic last_q, last_d;
  logic beat_q, beat_d;
  rec_t rec_q, rec_d;
  logic load;

  assign load = !valid_q || out_ready_i;

  // Pick the next record from the queue head
  always_comb begin
    valid_d = valid_q;
    last_d  = last_q;
    beat_d  = beat_q;
    rec_d   = rec_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = !q_empty_i;
      if (!q_empty_i) begin
        if (q_head_i.split && !beat_q) begin
          // Run record first, hold the entry for its status
          rec_d       = q_head_i.rec;
          rec_d.count = '0;
          last_d      = 1'b0;
          beat_d      = 1'b1;
        end else if (q_head_i.split) begin
          rec_d           = '0;
          rec_d.is_status = 1'b1;
          rec_d.code      = ST_OK;
          rec_d.count     = q_head_i.rec.count;
          last_d          = 1'b1;
          beat_d          = 1'b0;
          q_pop_o         = 1'b1;
        end else begin
          rec_d   = q_head_i.rec;
          last_d  = 1'b1;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      beat_q  <= beat_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_rec_o   = rec_q;
  assign out_last_o  = last_q;

endmodule

// ===== hw/rtl/printf_format_directive_parser.sv =====
// A result travels to the output through the queue write, then the output register.
// Throughput: one character request per cycle while the queue is not full; the
// parse step is combinational. An end marker closing an ordinary run gives two
// result beats, so its queue entry stays at the queue head until its status beat
// is loaded into the output register.
// Reset clears the parse state, the queue and the output; the limit reads 64.
module printf_format_directive_parser #(
  parameter int unsigned POSITION_BITS   = pdfp_pkg::POSITION_BITS_DEF,
  parameter int unsigned DIRECTIVE_LIMIT = pdfp_pkg::DIRECTIVE_LIMIT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pdfp_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: char_code[7:0]
  input  logic [7:0]                         s_axis_tdata,
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: directive_kind[3:0], field_width[19:4], zero_pad[20],
  // run_start[36:21], run_length[52:37], status_code[54:53],
  // error_position[70:55], directive_count[79:71]
  output logic [pdfp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: is_status[0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import pdfp_pkg::*;

  entry_t q_entry;
  entry_t q_head;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  rec_t   out_rec;

  pdfp_front #(
    .POSITION_BITS  (POSITION_BITS),
    .DIRECTIVE_LIMIT(DIRECTIVE_LIMIT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  pdfp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .pop_i  (q_pop),
    .head_o (q_head),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  pdfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_rec_o  (out_rec),
    .out_last_o (m_axis_tlast)
  );

  // Pack the record onto the stream
  assign m_axis_tdata = {out_rec.count, out_rec.epos, 2'(out_rec.code), out_rec.rlen,
                         out_rec.rstart, out_rec.zpad, out_rec.fwidth, out_rec.kind};
  assign m_axis_tuser = out_rec.is_status;

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("queue push while full");

  // Never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("queue pop while empty");

  // A status always closes the results of its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("status record not marked last");

  // Only an ordinary run record precedes another result of the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser && (m_axis_tdata[3:0] == KIND_ORD))
    else $error("non-final record is not an ordinary run");

endmodule

// ===== verif/tb_printf_format_directive_parser.sv =====
// Self-checking testbench for the printf format directive parser.
`timescale 1ns / 1ps

module tb_printf_format_directive_parser;
  import pdfp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned PHASE_CHARS = 190;
  localparam int unsigned LONG_RUN    = 40;

  // Parser position within a format string
  typedef enum logic [2:0] {
    SCAN_TEXT, SCAN_RUN, SCAN_FLAGS, SCAN_DIGITS,
    SCAN_LONG, SCAN_HALF, SCAN_CONV, SCAN_DISCARD
  } scan_e;

  typedef struct packed {
    logic [7:0] code;
    logic       eos;
  } fmt_char_t;

  typedef struct packed {
    logic        is_status;
    logic [3:0]  kind;
    logic [15:0] fwidth;
    logic        zpad;
    logic [15:0] rstart;
    logic [15:0] rlen;
    logic [1:0]  code;
    logic [15:0] epos;
    logic [8:0]  count;
    logic        end_of_step;
  } parse_rec_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  printf_format_directive_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Pending characters, expected records and run bookkeeping
  fmt_char_t   pending_chars[$];
  parse_rec_t  expected_records[$];
  int unsigned chars_queued    = 0;
  int unsigned chars_accepted  = 0;
  int unsigned strings_queued  = 0;
  int unsigned records_seen    = 0;
  int unsigned mismatch_count  = 0;
  int unsigned runs_predicted  = 0;
  int unsigned convs_predicted = 0;
  int unsigned errors_predicted = 0;
  int unsigned settings_used   = 0;
  int unsigned hold_at         = 0;
  logic        long_hold       = 1'b0;
  logic        quiet_tail      = 1'b0;
  int unsigned send_gap        = 0;
  int unsigned recv_gap        = 0;

  // Predictor state
  logic [8:0]  directive_cap = MAX_DIR_RESET;
  scan_e       scan_q        = SCAN_TEXT;
  logic [15:0] char_pos_q    = '0;
  logic [8:0]  dir_count_q   = '0;
  logic [15:0] run_start_q   = '0;
  logic [15:0] run_len_q     = '0;
  logic [15:0] width_acc_q   = '0;
  logic        zero_lead_q   = 1'b0;
  logic [1:0]  long_lvl_q    = '0;

  function automatic logic [8:0] cap_now();
    return (directive_cap > 9'(DIRECTIVE_LIMIT_DEF)) ? 9'(DIRECTIVE_LIMIT_DEF) : directive_cap;
  endfunction

  // Kind of a conversion character; KIND_ORD means invalid
  function automatic logic [3:0] conv_kind(logic [7:0] ch, logic [1:0] lvl);
    logic [3:0] base;
    case (ch)
      CH_D:    base = KIND_D;
      CH_U:    base = KIND_U;
      CH_X:    base = KIND_XL;
      CH_XU:   base = KIND_XU;
      default: base = KIND_ORD;
    endcase
    if (base != KIND_ORD) return base + {lvl, 2'b00};
    if (lvl == 2'd0) begin
      case (ch)
        CH_S: return KIND_S;
        CH_P: return KIND_P;
        CH_C: return KIND_C;
        default: return KIND_ORD;
      endcase
    end
    return KIND_ORD;
  endfunction

  function automatic string rec_text(parse_rec_t r);
    return $sformatf({"st=%0d kind=%0d w=%0d z=%0d start=%0d len=%0d ",
                      "code=%0d epos=%0d cnt=%0d last=%0d"},
                     r.is_status, r.kind, r.fwidth, r.zpad, r.rstart, r.rlen, r.code,
                     r.epos, r.count, r.end_of_step);
  endfunction

  task automatic add_directive(logic [3:0] kind, logic [15:0] wid, logic zp,
                               logic [15:0] start, logic [15:0] len, logic tail);
    parse_rec_t r;
    r = '0;
    r.kind = kind;
    r.fwidth = wid;
    r.zpad = zp;
    r.rstart = start;
    r.rlen = len;
    r.end_of_step = tail;
    expected_records.push_back(r);
    if (kind == KIND_ORD) runs_predicted++;
    else convs_predicted++;
  endtask

  task automatic add_status(status_e code, logic [15:0] at, logic tail);
    parse_rec_t r;
    r = '0;
    r.is_status = 1'b1;
    r.code = code;
    r.epos = at;
    r.count = dir_count_q;
    r.end_of_step = tail;
    expected_records.push_back(r);
    if (code != ST_OK) errors_predicted++;
  endtask

  task automatic restart_width();
    width_acc_q = '0;
    zero_lead_q = 1'b0;
    long_lvl_q = '0;
  endtask

  // Close a conversion: limit first, then validity
  task automatic close_conversion(logic [7:0] ch, logic [15:0] at);
    logic [3:0] k;
    k = conv_kind(ch, long_lvl_q);
    if (dir_count_q >= cap_now()) begin
      add_status(ST_TOO_MANY, at, 1'b1);
      scan_q = SCAN_DISCARD;
    end else if (k == KIND_ORD) begin
      add_status(ST_INVALID, at, 1'b1);
      scan_q = SCAN_DISCARD;
    end else begin
      add_directive(k, width_acc_q, zero_lead_q, '0, '0, 1'b1);
      dir_count_q++;
      scan_q = SCAN_TEXT;
    end
  endtask

  // Advance the predictor by one accepted request
  task automatic parse_char(logic [7:0] ch, logic eos);
    logic [15:0] at;
    int unsigned w;
    if (eos) begin
      case (scan_q)
        SCAN_TEXT: add_status(ST_OK, '0, 1'b1);
        SCAN_RUN: begin
          add_directive(KIND_ORD, '0, 1'b0, run_start_q, run_len_q, 1'b0);
          dir_count_q++;
          add_status(ST_OK, '0, 1'b1);
        end
        SCAN_DISCARD: ;
        default: add_status(ST_INVALID, char_pos_q, 1'b1);
      endcase
      scan_q = SCAN_TEXT;
      char_pos_q = '0;
      dir_count_q = '0;
      run_start_q = '0;
      run_len_q = '0;
      restart_width();
      return;
    end
    at = char_pos_q;
    if (char_pos_q != 16'hFFFF) char_pos_q++;
    case (scan_q)
      SCAN_TEXT: begin
        if (ch == CH_PCT) begin
          restart_width();
          scan_q = SCAN_FLAGS;
        end else if (dir_count_q >= cap_now()) begin
          add_status(ST_TOO_MANY, at, 1'b1);
          scan_q = SCAN_DISCARD;
        end else begin
          run_start_q = at;
          run_len_q = 16'd1;
          scan_q = SCAN_RUN;
        end
      end
      SCAN_RUN: begin
        if (ch == CH_PCT) begin
          add_directive(KIND_ORD, '0, 1'b0, run_start_q, run_len_q, 1'b1);
          dir_count_q++;
          restart_width();
          scan_q = SCAN_FLAGS;
        end else if (run_len_q != 16'hFFFF) begin
          run_len_q++;
        end
      end
      SCAN_FLAGS, SCAN_DIGITS: begin
        if (scan_q == SCAN_FLAGS && ch == CH_0) begin
          zero_lead_q = 1'b1;
          scan_q = SCAN_DIGITS;
        end else if (ch >= CH_0 && ch <= CH_9) begin
          w = 32'(width_acc_q) * 10 + 32'(ch) - 32'(CH_0);
          width_acc_q = (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
          scan_q = SCAN_DIGITS;
        end else if (ch == CH_DOT || ch == CH_DASH) begin
          restart_width();
          scan_q = SCAN_FLAGS;
        end else if (ch == CH_L) begin
          long_lvl_q = 2'd1;
          scan_q = SCAN_LONG;
        end else if (ch == CH_H) begin
          scan_q = SCAN_HALF;
        end else begin
          close_conversion(ch, at);
        end
      end
      SCAN_LONG: begin
        if (ch == CH_L) begin
          long_lvl_q = 2'd2;
          scan_q = SCAN_CONV;
        end else if (ch == CH_H) begin
          scan_q = SCAN_HALF;
        end else begin
          close_conversion(ch, at);
        end
      end
      SCAN_HALF: begin
        if (ch == CH_H) scan_q = SCAN_CONV;
        else close_conversion(ch, at);
      end
      SCAN_CONV: close_conversion(ch, at);
      default: scan_q = SCAN_DISCARD;
    endcase
  endtask

  // Drive character requests; predict each one as it is accepted
  always @(posedge clk_i) begin : drive_chars
    fmt_char_t nxt;
    logic offer;
    offer = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata, s_axis_tlast);
        chars_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_chars.size() > 0) begin
          if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 2);
          end else begin
            nxt = pending_chars.pop_front();
            s_axis_tdata <= nxt.code;
            s_axis_tlast <= nxt.eos;
            offer = 1'b1;
          end
        end
      end
    end
    s_axis_tvalid <= offer;
  end

  // Check each accepted record against the oldest expectation; drive ready
  always @(posedge clk_i) begin : check_records
    parse_rec_t got;
    parse_rec_t want;
    logic rdy;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.is_status = m_axis_tuser;
      got.kind = m_axis_tdata[3:0];
      got.fwidth = m_axis_tdata[19:4];
      got.zpad = m_axis_tdata[20];
      got.rstart = m_axis_tdata[36:21];
      got.rlen = m_axis_tdata[52:37];
      got.code = m_axis_tdata[54:53];
      got.epos = m_axis_tdata[70:55];
      got.count = m_axis_tdata[79:71];
      got.end_of_step = m_axis_tlast;
      records_seen++;
      if (expected_records.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected record at %0t: %s", $realtime, rec_text(got));
      end else begin
        want = expected_records.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: record %0d mismatch at %0t", records_seen, $realtime);
            $display("  expected %s", rec_text(want));
            $display("  actual   %s", rec_text(got));
          end
        end
      end
    end
    rdy = 1'b1;
    if (long_hold) begin
      rdy = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      rdy = 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 2);
      rdy = 1'b0;
    end
    m_axis_tready <= rdy;
  end

  // Hold the receiver off for a long stretch so the block backs up
  initial begin : receiver_hold
    wait (hold_at != 0 && chars_accepted >= hold_at);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Abort when no handshake happens on either side for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("ERROR: no handshake for %0d cycles, %0d records still expected",
             STALL_LIMIT, expected_records.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic push_char(logic [7:0] ch);
    pending_chars.push_back('{code: ch, eos: 1'b0});
    chars_queued++;
  endtask

  task automatic push_end();
    pending_chars.push_back('{code: 8'($urandom_range(0, 255)), eos: 1'b1});
    chars_queued++;
    strings_queued++;
  endtask

  task automatic push_digits(int unsigned n);
    repeat (n) push_char(CH_0 + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_plain(int unsigned n);
    logic [7:0] ch;
    repeat (n) begin
      do ch = 8'($urandom_range(0, 255)); while (ch == CH_PCT);
      push_char(ch);
    end
  endtask

  // Well-formed conversion with random flags, width and modifiers
  task automatic push_conversion();
    logic [1:0] lvl;
    int unsigned pick;
    push_char(CH_PCT);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: push_char(CH_0);
        1, 2: push_digits(($urandom_range(0, 7) == 0) ? 6 : $urandom_range(1, 3));
        3: push_char(CH_DOT);
        default: push_char(CH_DASH);
      endcase
    end
    lvl = 2'd0;
    case ($urandom_range(0, 6))
      1: begin push_char(CH_L); lvl = 2'd1; end
      2: begin push_char(CH_L); push_char(CH_L); lvl = 2'd2; end
      3: push_char(CH_H);
      4: begin push_char(CH_H); push_char(CH_H); end
      5: begin push_char(CH_L); push_char(CH_H); lvl = 2'd1; end
      6: begin push_char(CH_L); push_char(CH_H); push_char(CH_H); lvl = 2'd1; end
      default: ;
    endcase
    pick = (lvl != 0) ? $urandom_range(0, 3) : $urandom_range(0, 6);
    case (pick)
      0: push_char(CH_D);
      1: push_char(CH_U);
      2: push_char(CH_X);
      3: push_char(CH_XU);
      4: push_char(CH_S);
      5: push_char(CH_P);
      default: push_char(CH_C);
    endcase
  endtask

  // Broken conversions and noise; sets cut when the string must end here
  task automatic push_broken(output logic cut);
    cut = 1'b0;
    case ($urandom_range(0, 6))
      0: begin push_char(CH_PCT); push_char(CH_PCT); end
      1: begin push_char(CH_PCT); push_char(CH_L); push_char(CH_L); push_char(CH_H); end
      2: begin push_char(CH_PCT); push_char(CH_H); push_char(CH_L); end
      3: begin push_char(CH_PCT); push_char(CH_L); push_char(CH_S); end
      4: begin push_char(CH_PCT); push_char(8'($urandom_range(0, 255))); end
      5: begin
        // end of string inside a conversion
        push_char(CH_PCT);
        case ($urandom_range(0, 3))
          1: push_digits($urandom_range(1, 2));
          2: push_char(CH_L);
          3: push_char(CH_H);
          default: ;
        endcase
        cut = 1'b1;
      end
      default: repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic push_format_string();
    logic cut;
    int unsigned segs;
    int unsigned pick;
    segs = $urandom_range(1, 6);
    cut = 1'b0;
    for (int i = 0; i < segs && !cut; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) push_plain($urandom_range(1, 5));
      else if (pick < 85) push_conversion();
      else push_broken(cut);
    end
    push_end();
  endtask

  task automatic wait_drained();
    while (chars_accepted != chars_queued || expected_records.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [8:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    directive_cap = value;
    settings_used++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus: directed strings, then random strings under several limits
  initial begin : stimulus
    logic [8:0] caps [7];
    int unsigned phase_base;
    caps = '{9'd1, 9'd0, 9'd3, 9'd256, 9'd511, 9'd0, MAX_DIR_RESET};
    caps[5] = 9'($urandom_range(2, 12));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty string
    push_end();
    // zero-padded ll conversion, then a run closed by the end marker
    push_char(CH_PCT); push_char(CH_0); push_char(CH_0 + 8'd7);
    push_char(CH_L); push_char(CH_L); push_char(CH_XU);
    push_char(8'h00); push_char(8'hFF);
    push_end();
    // dash and dot restart the width; hh is dropped
    push_char(CH_PCT); push_char(CH_DASH); push_char(CH_0 + 8'd5);
    push_char(CH_DOT); push_char(CH_0 + 8'd3); push_char(CH_H);
    push_char(CH_H); push_char(CH_D);
    push_end();
    // percent percent, then end after the error
    push_char(CH_PCT); push_char(CH_PCT);
    push_end();
    // end inside a conversion
    push_char(CH_PCT); push_char(CH_0 + 8'd1);
    push_end();
    wait_drained();

    foreach (caps[p]) begin
      write_cap(caps[p]);
      if (p == 6) quiet_tail = 1'b1;
      phase_base = chars_queued;
      if (p == 3) hold_at = chars_accepted + 20;
      while (chars_queued - phase_base < PHASE_CHARS) push_format_string();
      if (p == 3) begin
        // one longer run closed by an invalid conversion
        push_plain(LONG_RUN);
        push_char(CH_PCT);
        push_char(CH_P + 8'd1);
        push_end();
      end
      wait_drained();
    end

    if (expected_records.size() != 0) begin
      mismatch_count++;
      $display("ERROR: %0d expected records never arrived", expected_records.size());
    end
    $display("Run covered %0d characters in %0d strings under %0d limit settings.",
             chars_accepted, strings_queued, settings_used);
    $display("Checked %0d records: %0d runs, %0d conversions, %0d error statuses.",
             records_seen, runs_predicted, convs_predicted, errors_predicted);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pdfp_pkg.sv
hw/rtl/pdfp_front.sv
hw/rtl/pdfp_fifo.sv
hw/rtl/pdfp_back.sv
hw/rtl/printf_format_directive_parser.sv
verif/tb_printf_format_directive_parser.sv
